[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// plain invariant
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`endif

[rtl/rau_pkg.sv]
package rau_pkg;
	typedef enum logic [2:0] {
		CMD_ADD = 3'd0, CMD_SUB = 3'd1, CMD_MUL = 3'd2, CMD_DIV = 3'd3, CMD_CMP = 3'd4
	} cmd_t;
	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_ZERO = 2'd1, ST_OVF = 2'd2
	} status_t;
	typedef enum logic [1:0] {
		ORD_LT = 2'd0, ORD_EQ = 2'd1, ORD_GT = 2'd2
	} order_t;
	// item classes as the front hands them to the back
	typedef enum logic [1:0] {
		CLS_ERR, CLS_ARITH, CLS_CMP
	} cls_t;
	typedef enum logic [3:0] {
		BK_IDLE, BK_MUL1, BK_MUL2, BK_FORM, BK_MOD, BK_GCD, BK_DIVN, BK_DIVD, BK_CHECK, BK_OUT
	} bk_state_t;
	localparam int unsigned MAG_W = 32;
endpackage

[rtl/rau_if.sv]
interface rau_if #(parameter int unsigned W = 8);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/rau_in_if.sv]
interface rau_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic        lhs_negative;
	logic [31:0] lhs_num;
	logic [31:0] lhs_den;
	logic        rhs_negative;
	logic [31:0] rhs_num;
	logic [31:0] rhs_den;
	modport source(output valid, cmd, lhs_negative, lhs_num, lhs_den, rhs_negative, rhs_num,
		rhs_den, input ready);
	modport sink(input valid, cmd, lhs_negative, lhs_num, lhs_den, rhs_negative, rhs_num,
		rhs_den, output ready);
endinterface

[rtl/rau_out_if.sv]
interface rau_out_if;
	logic        valid;
	logic        ready;
	logic        res_negative;
	logic [31:0] res_num;
	logic [31:0] res_den;
	logic [1:0]  order;
	logic [1:0]  status;
	modport source(output valid, res_negative, res_num, res_den, order, status, input ready);
	modport sink(input valid, res_negative, res_num, res_den, order, status, output ready);
endinterface

[rtl/rau_front.sv]
// Masks operands, classifies the command and pushes a job into a two-entry queue.
module rau_front #(
	parameter int unsigned WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	rau_in_if.sink              in_ch,
	rau_if.source               job
);
	import rau_pkg::*;
	localparam int unsigned JW = 2 + 3 + 2 + 4 * WIDTH;
	localparam int unsigned DEPTH = 2;

	logic [JW-1:0] fifo_q [DEPTH];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    cnt_q;
	logic [WIDTH-1:0] ln, ld, rn, rd;
	logic ls, rs;
	cls_t cls;
	logic [JW-1:0] entry;
	logic push, pop;

	always_comb begin
		ln = in_ch.lhs_num[WIDTH-1:0];
		ld = in_ch.lhs_den[WIDTH-1:0];
		rn = in_ch.rhs_num[WIDTH-1:0];
		rd = in_ch.rhs_den[WIDTH-1:0];
		ls = in_ch.lhs_negative && (ln != '0);
		rs = in_ch.rhs_negative && (rn != '0);
		if (ld == '0 || rd == '0 || (in_ch.cmd == CMD_DIV && rn == '0)) begin
			cls = CLS_ERR;
		end else if (in_ch.cmd <= CMD_DIV) begin
			cls = CLS_ARITH;
		end else begin
			cls = CLS_CMP;
		end
		entry = {cls, in_ch.cmd, ls, rs, ln, ld, rn, rd};
	end

	assign in_ch.ready = (cnt_q != 2'(DEPTH));
	assign push = in_ch.valid && in_ch.ready;
	assign pop = job.valid && job.ready;
	assign job.valid = (cnt_q != 2'd0);
	assign job.data = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

[rtl/rau_back.sv]
// Executes one job: cross products, then for arithmetic jobs the exact
// numerator, Euclidean gcd by restoring division, two gcd divisions.
module rau_back #(
	parameter int unsigned WIDTH = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	rau_if.sink   job,
	rau_out_if.source out_ch
);
	import rau_pkg::*;
	localparam int unsigned JW = 2 + 3 + 2 + 4 * WIDTH;
	localparam int unsigned PW = 2 * WIDTH;
	localparam int unsigned NW = PW + 1;
	localparam int unsigned CW = $clog2(NW + 1);

	bk_state_t state_q, state_d;
	cls_t cls_q;
	cmd_t cmd_q;
	logic ls_q, rs_q;
	logic [WIDTH-1:0] ln_q, ld_q, rn_q, rd_q;
	logic [PW-1:0] p_q, q_q, d_q;
	logic [NW-1:0] n_q;
	logic neg_q;
	// shared restoring divider
	logic [NW-1:0] dv_a_q, dv_quo_q, dv_rem_q;
	logic [PW-1:0] dv_b_q;
	logic [CW-1:0] dv_cnt_q;
	logic [PW-1:0] ga_q, gb_q;
	logic [NW-1:0] numr_q;
	logic [PW-1:0] denr_q;
	logic [1:0] mulph_q;
	logic [PW-1:0] mul_r;
	logic [WIDTH-1:0] ma, mb;
	logic [NW:0] rem_sh;
	logic dv_done;
	logic res_neg_q;
	logic [WIDTH-1:0] res_num_q, res_den_q;
	logic [1:0] ord_q, st_q;
	logic out_v_q;
	logic es;

	assign mul_r = PW'(ma) * PW'(mb);
	assign rem_sh = {dv_rem_q, dv_a_q[NW-1]};
	assign dv_done = (dv_cnt_q == CW'(NW));
	assign es = (cmd_q == CMD_SUB) ? (!rs_q && rn_q != '0) : rs_q;

	always_comb begin
		unique case (mulph_q)
			2'd0: begin ma = ln_q; mb = rd_q; end
			2'd1: begin ma = rn_q; mb = ld_q; end
			default: begin ma = ld_q; mb = rd_q; end
		endcase
		if (cmd_q == CMD_MUL && mulph_q == 2'd0) mb = rn_q;
		if (cmd_q == CMD_DIV && mulph_q == 2'd2) mb = rn_q;
	end

	assign job.ready = (state_q == BK_IDLE) && !out_v_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (job.valid && job.ready) state_d = BK_MUL1;
			BK_MUL1: if (mulph_q == 2'd2) state_d = BK_MUL2;
			BK_MUL2: state_d = (cls_q == CLS_ARITH) ? BK_FORM : BK_OUT;
			BK_FORM: state_d = BK_MOD;
			BK_MOD: if (dv_done) state_d = BK_GCD;
			BK_GCD: if (gb_q == '0) state_d = BK_DIVN;
			BK_DIVN: if (dv_done) state_d = BK_DIVD;
			BK_DIVD: if (dv_done) state_d = BK_CHECK;
			BK_CHECK: state_d = BK_OUT;
			BK_OUT: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_OUT) out_v_q <= 1'b1;
			else if (out_ch.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		// divider step runs whenever armed and not finished
		if (!dv_done) begin
			if (rem_sh >= {1'b0, dv_b_q}) begin
				dv_rem_q <= NW'(rem_sh - {1'b0, dv_b_q});
				dv_quo_q <= {dv_quo_q[NW-2:0], 1'b1};
			end else begin
				dv_rem_q <= rem_sh[NW-1:0];
				dv_quo_q <= {dv_quo_q[NW-2:0], 1'b0};
			end
			dv_a_q <= {dv_a_q[NW-2:0], 1'b0};
			dv_cnt_q <= dv_cnt_q + CW'(1);
		end
		unique case (state_q)
			BK_IDLE: begin
				dv_cnt_q <= CW'(NW);
				mulph_q <= 2'd0;
				cls_q <= cls_t'(job.data[JW-1 -: 2]);
				cmd_q <= cmd_t'(job.data[JW-3 -: 3]);
				{ls_q, rs_q, ln_q, ld_q, rn_q, rd_q} <= job.data[JW-6:0];
			end
			BK_MUL1: begin
				unique case (mulph_q)
					2'd0: p_q <= mul_r;
					2'd1: q_q <= mul_r;
					default: d_q <= mul_r;
				endcase
				mulph_q <= mulph_q + 2'd1;
			end
			BK_MUL2: begin
				if (cmd_q == CMD_MUL || cmd_q == CMD_DIV) begin
					n_q <= {1'b0, p_q};
					neg_q <= ls_q != rs_q;
				end else if (ls_q == es) begin
					n_q <= NW'({1'b0, p_q} + {1'b0, q_q});
					neg_q <= ls_q;
				end else if (p_q >= q_q) begin
					n_q <= {1'b0, p_q - q_q};
					neg_q <= ls_q;
				end else begin
					n_q <= {1'b0, q_q - p_q};
					neg_q <= es;
				end
			end
			BK_FORM: begin
				dv_a_q <= n_q; dv_b_q <= d_q; dv_rem_q <= '0; dv_quo_q <= '0;
				dv_cnt_q <= '0;
			end
			BK_MOD: if (dv_done) begin
				ga_q <= d_q; gb_q <= dv_rem_q[PW-1:0];
				dv_a_q <= {1'b0, d_q}; dv_b_q <= dv_rem_q[PW-1:0];
				dv_rem_q <= '0; dv_quo_q <= '0;
				dv_cnt_q <= (dv_rem_q == '0) ? CW'(NW) : '0;
			end
			BK_GCD: if (gb_q == '0) begin
				dv_a_q <= n_q; dv_b_q <= ga_q; dv_rem_q <= '0; dv_quo_q <= '0;
				dv_cnt_q <= '0;
			end else if (dv_done) begin
				// advance Euclid: (a, b) <- (b, a mod b)
				ga_q <= gb_q; gb_q <= dv_rem_q[PW-1:0];
				dv_a_q <= {1'b0, gb_q}; dv_b_q <= dv_rem_q[PW-1:0];
				dv_rem_q <= '0; dv_quo_q <= '0;
				dv_cnt_q <= (dv_rem_q == '0) ? CW'(NW) : '0;
			end
			BK_DIVN: if (dv_done) begin
				numr_q <= dv_quo_q;
				dv_a_q <= {1'b0, d_q}; dv_b_q <= ga_q; dv_rem_q <= '0; dv_quo_q <= '0;
				dv_cnt_q <= '0;
			end
			BK_DIVD: if (dv_done) denr_q <= dv_quo_q[PW-1:0];
			BK_CHECK: begin
				res_neg_q <= 1'b0; res_num_q <= '0; res_den_q <= WIDTH'(1);
				ord_q <= ORD_LT;
				if ((numr_q >> WIDTH) != '0 || (denr_q >> WIDTH) != '0) begin
					st_q <= ST_OVF;
				end else begin
					st_q <= ST_OK;
					res_num_q <= numr_q[WIDTH-1:0];
					res_den_q <= denr_q[WIDTH-1:0];
					res_neg_q <= neg_q && (numr_q != '0);
				end
			end
			BK_OUT: if (cls_q != CLS_ARITH) begin
				res_neg_q <= 1'b0; res_num_q <= '0; res_den_q <= WIDTH'(1);
				ord_q <= ORD_LT;
				st_q <= (cls_q == CLS_ERR) ? ST_ZERO : ST_OK;
				if (cls_q == CLS_CMP) begin
					if (ls_q != rs_q) ord_q <= ls_q ? ORD_LT : ORD_GT;
					else if (p_q == q_q) ord_q <= ORD_EQ;
					else if ((p_q < q_q) != ls_q) ord_q <= ORD_LT;
					else ord_q <= ORD_GT;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.res_negative = res_neg_q;
	assign out_ch.res_num = MAG_W'(res_num_q);
	assign out_ch.res_den = MAG_W'(res_den_q);
	assign out_ch.order = ord_q;
	assign out_ch.status = st_q;
endmodule

[rtl/rational_arithmetic_unit.sv]
// Rational arithmetic unit: add, subtract, multiply, divide or compare two sign-magnitude
// fractions, reducing results to lowest terms. One item is executed at a time; a two-entry
// input queue accepts items while the back end works. Every remainder comes from one
// bit-serial restoring divider stepping one quotient bit per cycle. Compare and error
// items skip the divider.
module rational_arithmetic_unit #(
	parameter int unsigned WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	rau_in_if.sink in_ch,
	rau_out_if.source out_ch
);
	import rau_pkg::*;
	`include "assert_macros.svh"

	localparam int unsigned JW = 2 + 3 + 2 + 4 * WIDTH;
	rau_if #(.W(JW)) job ();

	rau_front #(.WIDTH(WIDTH)) u_front (.clk, .arst_n, .in_ch, .job(job.source));
	rau_back #(.WIDTH(WIDTH)) u_back (.clk, .arst_n, .job(job.sink), .out_ch);

	`ASSERT_IMPL(a_err_zero, clk, arst_n, out_ch.valid && out_ch.status != ST_OK,
		out_ch.res_num == '0 && out_ch.res_den == 32'd1 && !out_ch.res_negative,
		"error result not 0/1")
	`ASSERT_IMPL(a_zero_pos, clk, arst_n, out_ch.valid && out_ch.res_num == '0,
		!out_ch.res_negative, "zero result negative")
	`ASSERT_ALWAYS(a_status_rng, clk, arst_n, !out_ch.valid || out_ch.status != 2'd3,
		"bad status code")
endmodule

[test/rational_arithmetic_unit_test.sv]
module rational_arithmetic_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import rau_pkg::*;

	typedef struct packed {
		logic [2:0]  cmd;
		logic        lneg;
		logic [31:0] lnum;
		logic [31:0] lden;
		logic        rneg;
		logic [31:0] rnum;
		logic [31:0] rden;
	} operands_t;

	typedef struct packed {
		logic        neg;
		logic [31:0] num;
		logic [31:0] den;
		logic [1:0]  order;
		logic [1:0]  status;
	} fraction_result_t;

	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	logic clk;
	logic arst_n;
	rau_in_if in_ch();
	rau_out_if out_ch();

	rational_arithmetic_unit #(.WIDTH(32)) u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	fraction_result_t pending_results[$];
	int errors = 0;
	bit idle_enable = 1'b1;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// Exact rational arithmetic on a 65-bit numerator, then reduce.
	function automatic fraction_result_t compute_fraction(operands_t op);
		fraction_result_t r;
		logic ls, rs, es;
		logic [64:0] n, p, q, g, nn;
		logic [63:0] d, dd;
		r = '{neg: 1'b0, num: 32'd0, den: 32'd1, order: ORD_LT, status: ST_OK};
		ls = op.lneg && op.lnum != 0;
		rs = op.rneg && op.rnum != 0;
		if (op.lden == 0 || op.rden == 0 || (op.cmd == CMD_DIV && op.rnum == 0)) begin
			r.status = ST_ZERO;
			return r;
		end
		p = 64'(op.lnum) * 64'(op.rden);
		q = 64'(op.rnum) * 64'(op.lden);
		if (op.cmd > CMD_DIV) begin
			if (ls != rs) r.order = ls ? ORD_LT : ORD_GT;
			else if (p == q) r.order = ORD_EQ;
			else if ((p < q) != ls) r.order = ORD_LT;
			else r.order = ORD_GT;
			return r;
		end
		if (op.cmd == CMD_ADD || op.cmd == CMD_SUB) begin
			es = (op.cmd == CMD_SUB) ? (!rs && op.rnum != 0) : rs;
			d = 64'(op.lden) * 64'(op.rden);
			if (ls == es) begin
				n = p + q;
				r.neg = ls;
			end else if (p >= q) begin
				n = p - q;
				r.neg = ls;
			end else begin
				n = q - p;
				r.neg = es;
			end
		end else if (op.cmd == CMD_MUL) begin
			n = 64'(op.lnum) * 64'(op.rnum);
			d = 64'(op.lden) * 64'(op.rden);
			r.neg = ls != rs;
		end else begin
			n = p;
			d = 64'(op.lden) * 64'(op.rnum);
			r.neg = ls != rs;
		end
		g = 65'(gcd64(d, 64'(n % 65'(d))));
		nn = n / g;
		dd = d / g[63:0];
		if (nn[64:32] != 0 || dd[63:32] != 0) begin
			r.status = ST_OVF;
			r.neg = 1'b0;
			return r;
		end
		r.num = nn[31:0];
		r.den = dd[31:0];
		if (r.num == 0) r.neg = 1'b0;
		return r;
	endfunction

	task automatic send_operands(operands_t op);
		while (idle_enable && $urandom_range(99) < 11) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		{in_ch.cmd, in_ch.lhs_negative, in_ch.lhs_num, in_ch.lhs_den,
			in_ch.rhs_negative, in_ch.rhs_num, in_ch.rhs_den} <= op;
		do @(posedge clk); while (!in_ch.ready);
		pending_results.push_back(compute_fraction(op));
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(7))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'hFFFF_FFFF;
			3: return $urandom();
			4: return 32'h8000_0000 >> $urandom_range(31);
			default: return $urandom_range(40);
		endcase
	endfunction

	function automatic operands_t random_operands();
		operands_t op;
		op.cmd = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
		op.lneg = 1'($urandom_range(1));
		op.rneg = 1'($urandom_range(1));
		op.lnum = pick_value();
		op.rnum = pick_value();
		op.lden = pick_value();
		op.rden = pick_value();
		// keep error items rare
		if (op.lden == 0 && $urandom_range(7) != 0) op.lden = 1;
		if (op.rden == 0 && $urandom_range(7) != 0) op.rden = 3;
		return op;
	endfunction

	task automatic test_directed();
		send_operands({CMD_ADD, 1'b0, 32'd1, 32'd2, 1'b0, 32'd1, 32'd3});
		send_operands({CMD_SUB, 1'b0, 32'd1, 32'd2, 1'b0, 32'd1, 32'd2});
		send_operands({CMD_MUL, 1'b1, 32'd3, 32'd4, 1'b0, 32'd2, 32'd9});
		send_operands({CMD_DIV, 1'b1, 32'd3, 32'd4, 1'b1, 32'd5, 32'd7});
		send_operands({CMD_CMP, 1'b0, 32'd2, 32'd4, 1'b0, 32'd1, 32'd2});
		send_operands({CMD_CMP, 1'b1, 32'd0, 32'd4, 1'b0, 32'd0, 32'd2});
		send_operands({CMD_CMP, 1'b1, 32'd3, 32'd4, 1'b1, 32'd1, 32'd2});
		send_operands({3'd5, 1'b0, 32'd1, 32'd4, 1'b0, 32'd1, 32'd2});
		send_operands({3'd7, 1'b1, 32'd1, 32'd4, 1'b0, 32'd1, 32'd2});
		send_operands({CMD_ADD, 1'b0, 32'd1, 32'd0, 1'b0, 32'd1, 32'd1});
		send_operands({CMD_MUL, 1'b0, 32'd1, 32'd1, 1'b0, 32'd1, 32'd0});
		send_operands({CMD_DIV, 1'b0, 32'd1, 32'd1, 1'b1, 32'd0, 32'd1});
		send_operands({CMD_ADD, 1'b0, ALL_ONES, 32'd1, 1'b0, ALL_ONES, 32'd1});
		send_operands({CMD_ADD, 1'b1, ALL_ONES, ALL_ONES, 1'b1, ALL_ONES, ALL_ONES});
		send_operands({CMD_SUB, 1'b1, ALL_ONES, 32'd1, 1'b0, ALL_ONES, 32'd1});
		send_operands({CMD_MUL, 1'b0, ALL_ONES, 32'd1, 1'b0, ALL_ONES, 32'd1});
		send_operands({CMD_DIV, 1'b0, 32'd1, ALL_ONES, 1'b0, ALL_ONES, 32'd1});
		send_operands({CMD_MUL, 1'b1, 32'd0, ALL_ONES, 1'b1, ALL_ONES, ALL_ONES});
		send_operands({CMD_SUB, 1'b0, 32'd5, 32'd3, 1'b1, 32'd0, 32'd7});
		send_operands({CMD_CMP, 1'b0, ALL_ONES, 32'd1, 1'b0, ALL_ONES, 32'd1});
		send_operands({CMD_CMP, 1'b1, 32'd1, ALL_ONES, 1'b0, 32'd1, ALL_ONES});
	endtask

	task automatic test_drain_pause();
		send_operands({CMD_DIV, 1'b0, 32'd6, 32'd35, 1'b0, 32'd10, 32'd21});
		// hold until every expected transfer has come back
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		send_operands({CMD_ADD, 1'b1, 32'd7, 32'd6, 1'b0, 32'd5, 32'd4});
	endtask

	task automatic test_random(int count);
		repeat (count) send_operands(random_operands());
	endtask

	task automatic test_no_idle(int count);
		idle_enable = 1'b0;
		test_random(count);
		idle_enable = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !idle_enable || $urandom_range(99) >= 11;
		end
	end

	always @(posedge clk) begin
		fraction_result_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.res_negative, out_ch.res_num, out_ch.res_den, out_ch.order,
				out_ch.status};
			if (pending_results.size() == 0) begin
				$display("%t: unexpected result %h", $realtime, got);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.neg !== want.neg) begin
					$display("%t: sign expected %b actual %b", $realtime, want.neg, got.neg);
					errors++;
				end
				if (got.num !== want.num) begin
					$display("%t: num expected %h actual %h", $realtime, want.num, got.num);
					errors++;
				end
				if (got.den !== want.den) begin
					$display("%t: den expected %h actual %h", $realtime, want.den, got.den);
					errors++;
				end
				if (got.order !== want.order) begin
					$display("%t: order expected %0d actual %0d", $realtime, want.order,
						got.order);
					errors++;
				end
				if (got.status !== want.status) begin
					$display("%t: status expected %0d actual %0d", $realtime, want.status,
						got.status);
					errors++;
				end
			end
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		{in_ch.cmd, in_ch.lhs_negative, in_ch.lhs_num, in_ch.lhs_den,
			in_ch.rhs_negative, in_ch.rhs_num, in_ch.rhs_den} = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_drain_pause();
		test_random(600);
		test_no_idle(200);
		test_random(330);
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

	initial begin
		#200ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule
